FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_CLK_MSG(lbl, clk, rstn, prop, msg)
`endif

`endif

FILE: rtl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types, codes and frame constants of the command framer.
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] REG_VOLUME_STEP = 2'd0;
    localparam logic [1:0] REG_VOLUME_MAX  = 2'd1;
    localparam logic [1:0] REG_TRACK_MAX   = 2'd2;

    // Request codes
    localparam logic [7:0] REQ_NONE      = 8'h00;
    localparam logic [7:0] VOL_DOWN      = 8'h01;
    localparam logic [7:0] VOL_UP        = 8'h02;
    localparam logic [7:0] MUS_FIRST     = 8'h01;
    localparam logic [7:0] MUS_NEXT      = 8'h02;
    localparam logic [7:0] MUS_PREV      = 8'h03;
    localparam logic [7:0] MUS_STOP      = 8'h04;

    // Frame bytes
    localparam logic [7:0] FRM_START     = 8'h7E;
    localparam logic [7:0] FRM_VERSION   = 8'hFF;
    localparam logic [7:0] FRM_LENGTH    = 8'h06;
    localparam logic [7:0] FRM_P1        = 8'h00;
    localparam logic [7:0] FRM_END       = 8'hEF;
    localparam logic [7:0] CMD_VOLUME    = 8'h06;
    localparam logic [7:0] CMD_PROMPT    = 8'h0F;
    localparam logic [7:0] CMD_PLAY      = 8'h12;
    localparam logic [7:0] CMD_STOP      = 8'h16;
    localparam logic [7:0] P2_PROMPT     = 8'h02;
    localparam logic [7:0] P2_NONE       = 8'h00;

    // Reset values
    localparam logic [3:0] RST_VOLUME_STEP = 4'd2;
    localparam logic [7:0] RST_VOLUME_MAX  = 8'd30;
    localparam logic [7:0] RST_TRACK_MAX   = 8'd7;
    localparam logic [7:0] RST_VOLUME      = 8'd8;
    localparam logic [7:0] RST_TRACK       = 8'd1;
    localparam logic [7:0] RST_PROMPT      = 8'd1;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] p2;
        logic [7:0] value;
        logic       last;
    } mpf_frame_t;

    function automatic logic [7:0] mpf_frame_byte(mpf_frame_t frm, logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = FRM_START;
            3'd1:    b = FRM_VERSION;
            3'd2:    b = FRM_LENGTH;
            3'd3:    b = frm.cmd;
            3'd4:    b = FRM_P1;
            3'd5:    b = frm.p2;
            3'd6:    b = frm.value;
            default: b = FRM_END;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/mpf_front.sv
// ----------------------------------------------------------------------------
// mpf_front
// Accepts requests, updates the stored player state and hands up to three
// frame descriptors, one per cycle while the queue is not full, to the frame queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         volume_request,
    input  logic [7:0]         prompt_request,
    input  logic [7:0]         music_request,
    output logic               q_push,
    output mpf_pkg::mpf_frame_t q_data,
    input  logic               q_full
);
    import mpf_pkg::*;

    logic [3:0] volume_step_reg;
    logic [7:0] volume_max_reg;
    logic [7:0] track_max_reg;
    logic [7:0] volume_reg, volume_next;
    logic [7:0] track_reg, track_next;
    logic [7:0] prompt_reg;
    logic [2:0] pend_reg, pend_next;
    mpf_frame_t desc_reg [3];
    mpf_frame_t desc_next [3];
    logic       accept;
    logic       pend_single;
    logic [7:0] tmax;
    logic [8:0] vol_sum;
    logic       has_vol, has_prm, has_mus;

    assign has_vol = (volume_request != REQ_NONE);
    assign has_prm = (prompt_request != REQ_NONE);
    assign has_mus = (music_request  != REQ_NONE);

    // A new request may enter once at most one frame is left and it leaves now.
    assign pend_single = ((pend_reg & (pend_reg - 3'd1)) == 3'd0);
    assign in_stall    = (pend_reg != 3'd0) && !(pend_single && !q_full);
    assign accept      = in_valid && !in_stall;
    assign q_push      = (pend_reg != 3'd0) && !q_full;

    always_comb
    begin
        if (pend_reg[0])
            q_data = desc_reg[0];
        else if (pend_reg[1])
            q_data = desc_reg[1];
        else
            q_data = desc_reg[2];
    end

    always_comb
    begin
        tmax    = (track_max_reg == 8'd0) ? 8'd1 : track_max_reg;
        vol_sum = {1'b0, volume_reg} + {5'd0, volume_step_reg};

        case (volume_request)
            VOL_DOWN:
                volume_next = (volume_reg > {4'd0, volume_step_reg})
                            ? volume_reg - {4'd0, volume_step_reg} : 8'd0;
            VOL_UP:
                volume_next = (vol_sum > {1'b0, volume_max_reg})
                            ? volume_max_reg : vol_sum[7:0];
            default:
                volume_next = volume_reg;
        endcase

        case (music_request)
            MUS_FIRST: track_next = 8'd1;
            MUS_NEXT:  track_next = (track_reg >= tmax) ? 8'd1 : track_reg + 8'd1;
            MUS_PREV:  track_next = (track_reg <= 8'd1 || track_reg > tmax)
                                  ? tmax : track_reg - 8'd1;
            default:   track_next = track_reg;
        endcase

        desc_next[0] = '{cmd: CMD_VOLUME, p2: P2_NONE, value: volume_next,
                         last: !(has_prm || has_mus)};
        desc_next[1] = '{cmd: CMD_PROMPT, p2: P2_PROMPT, value: prompt_request,
                         last: !has_mus};
        if (music_request == MUS_STOP)
            desc_next[2] = '{cmd: CMD_STOP, p2: P2_NONE, value: 8'd0, last: 1'b1};
        else
            desc_next[2] = '{cmd: CMD_PLAY, p2: P2_NONE, value: track_next, last: 1'b1};

        pend_next = pend_reg;
        if (q_push)
        begin
            if (pend_reg[0])
                pend_next[0] = 1'b0;
            else if (pend_reg[1])
                pend_next[1] = 1'b0;
            else
                pend_next[2] = 1'b0;
        end
        if (accept)
            pend_next = {has_mus, has_prm, has_vol};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_step_reg <= RST_VOLUME_STEP;
            volume_max_reg  <= RST_VOLUME_MAX;
            track_max_reg   <= RST_TRACK_MAX;
            volume_reg      <= RST_VOLUME;
            track_reg       <= RST_TRACK;
            prompt_reg      <= RST_PROMPT;
            pend_reg        <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_VOLUME_STEP: volume_step_reg <= cfg_data[3:0];
                    REG_VOLUME_MAX:  volume_max_reg  <= cfg_data;
                    REG_TRACK_MAX:   track_max_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            if (accept)
            begin
                if (has_vol)
                    volume_reg <= volume_next;
                if (has_prm)
                    prompt_reg <= prompt_request;
                if (has_mus)
                    track_reg <= track_next;
            end
        end
    end

    // The stored prompt is only mirrored out through its frame.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg[0] <= desc_next[0];
            desc_reg[1] <= (has_prm) ? desc_next[1]
                         : '{cmd: CMD_PROMPT, p2: P2_PROMPT, value: prompt_reg,
                             last: 1'b0};
            desc_reg[2] <= desc_next[2];
        end
    end

    `ASSERT_CLK(a_push_not_full, clk, rst_n, q_push |-> !q_full)
    `ASSERT_CLK(a_vol_pending, clk, rst_n, (accept && has_vol) |=> pend_reg[0])
    `ASSERT_CLK(a_no_music_frame, clk, rst_n, (accept && !has_mus) |=> !pend_reg[2])

endmodule

FILE: rtl/mpf_queue.sv
// ----------------------------------------------------------------------------
// mpf_queue
// Short first-in first-out store of frame descriptors between front and back.
// ----------------------------------------------------------------------------
module mpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mpf_pkg::mpf_frame_t push_data,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output mpf_pkg::mpf_frame_t head_data
);
    import mpf_pkg::*;

    mpf_frame_t          mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/mpf_back.sv
// ----------------------------------------------------------------------------
// mpf_back
// Serialises queued frame descriptors into bytes through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mpf_pkg::mpf_frame_t head_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          tx_byte,
    output logic                last_byte
);
    import mpf_pkg::*;

    mpf_frame_t  frame_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        last_reg;
    mpf_frame_t  cur;
    logic        have;
    logic        load;

    // Byte zero of a frame comes straight from the queue head.
    assign cur  = (idx_reg == 3'd0) ? head_data : frame_reg;
    assign have = (idx_reg != 3'd0) || head_valid;
    assign load = have && (!out_valid_reg || !out_stall);
    assign pop  = load && (idx_reg == 3'd0);

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= idx_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            frame_reg <= head_data;
        if (load)
        begin
            tx_byte_reg <= mpf_frame_byte(cur, idx_reg);
            last_reg    <= cur.last && (idx_reg == 3'd7);
        end
    end

    `ASSERT_CLK(a_pop_has_data, clk, rst_n, pop |-> head_valid)
    `ASSERT_CLK(a_mid_frame_shown, clk, rst_n, (idx_reg != 3'd0) |-> out_valid_reg)
    `ASSERT_CLK_MSG(a_last_ends_frame, clk, rst_n,
        (out_valid_reg && last_reg) |-> (idx_reg == 3'd0), "last byte inside a frame")

endmodule

FILE: rtl/mp3_player_command_framer_top.sv
// ----------------------------------------------------------------------------
// mp3_player_command_framer_top
// Turns volume, prompt and music requests into serial command frames.
// ----------------------------------------------------------------------------
// Each accepted request yields one eight-byte frame (7E FF 06 cmd 00 p2 value
// EF) for every nonzero code, in the order volume, prompt, music, so a request
// produces 0, 8, 16 or 24 output transactions; last_byte marks the final one.
// Bytes leave at one per cycle while out_stall is low, stepped by the byte
// counter of the serialiser. The front end updates the stored volume,
// prompt and track at acceptance and hands frame descriptors to a
// four-entry queue, so the next request is taken while earlier frames are
// still being sent. Requests with all codes zero produce nothing.
module mp3_player_command_framer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] volume_request,
    input  logic [7:0] prompt_request,
    input  logic [7:0] music_request,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] tx_byte,
    output logic       last_byte
);
    import mpf_pkg::*;

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_head_valid;
    mpf_frame_t q_push_data;
    mpf_frame_t q_head_data;

    mpf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .volume_request (volume_request),
        .prompt_request (prompt_request),
        .music_request  (music_request),
        .q_push         (q_push),
        .q_data         (q_push_data),
        .q_full         (q_full)
    );

    mpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    mpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .last_byte  (last_byte)
    );

endmodule

FILE: dv/mp3_player_command_framer_checker.sv
// ----------------------------------------------------------------------------
// mp3_player_command_framer_checker
// Watches the request, frame and register ports of the command framer, keeps
// its own copy of volume, prompt and track state, predicts the bytes of every
// command frame and compares them with what the block sends.
// ----------------------------------------------------------------------------
module mp3_player_command_framer_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] volume_request,
    input  logic [7:0] prompt_request,
    input  logic [7:0] music_request,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] tx_byte,
    input  logic       last_byte,
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mpf_pkg::*;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
    } serial_byte_t;

    serial_byte_t frame_bytes_due[$];
    serial_byte_t oldest;

    logic [3:0] vol_step;
    logic [7:0] vol_ceiling;
    logic [7:0] track_ceiling;
    logic [7:0] vol_level;
    logic [7:0] track_no;
    logic [7:0] prompt_no;
    int         mismatches;

    task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] p2,
                               input logic [7:0] value);
        frame_bytes_due.push_back({FRM_START, 1'b0});
        frame_bytes_due.push_back({FRM_VERSION, 1'b0});
        frame_bytes_due.push_back({FRM_LENGTH, 1'b0});
        frame_bytes_due.push_back({cmd, 1'b0});
        frame_bytes_due.push_back({FRM_P1, 1'b0});
        frame_bytes_due.push_back({p2, 1'b0});
        frame_bytes_due.push_back({value, 1'b0});
        frame_bytes_due.push_back({FRM_END, 1'b0});
    endtask

    // Updates the stored state for one request and queues the frames it causes.
    task automatic predict_request(input logic [7:0] vreq, input logic [7:0] preq,
                                   input logic [7:0] mreq);
        logic [7:0]   tmax_eff;
        logic [8:0]   raised;
        int           queued_before;
        serial_byte_t final_byte;
        queued_before = frame_bytes_due.size();
        tmax_eff = (track_ceiling == 8'd0) ? 8'd1 : track_ceiling;
        if (vreq != REQ_NONE)
        begin
            if (vreq == VOL_DOWN)
                vol_level = (vol_level > vol_step) ? vol_level - vol_step : 8'd0;
            else if (vreq == VOL_UP)
            begin
                raised = vol_level + vol_step;
                vol_level = (raised > vol_ceiling) ? vol_ceiling : raised[7:0];
            end
            queue_frame(CMD_VOLUME, P2_NONE, vol_level);
        end
        if (preq != REQ_NONE)
        begin
            prompt_no = preq;
            queue_frame(CMD_PROMPT, P2_PROMPT, prompt_no);
        end
        if (mreq != REQ_NONE)
        begin
            if (mreq == MUS_STOP)
                queue_frame(CMD_STOP, P2_NONE, 8'd0);
            else
            begin
                if (mreq == MUS_FIRST)
                    track_no = 8'd1;
                else if (mreq == MUS_NEXT)
                    track_no = (track_no >= tmax_eff) ? 8'd1 : track_no + 8'd1;
                else if (mreq == MUS_PREV)
                    track_no = (track_no <= 8'd1 || track_no > tmax_eff)
                             ? tmax_eff : track_no - 8'd1;
                queue_frame(CMD_PLAY, P2_NONE, track_no);
            end
        end
        // Only the very last byte of the whole request carries the end marker.
        if (frame_bytes_due.size() > queued_before)
        begin
            final_byte = frame_bytes_due.pop_back();
            final_byte.last = 1'b1;
            frame_bytes_due.push_back(final_byte);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_step      = RST_VOLUME_STEP;
            vol_ceiling   = RST_VOLUME_MAX;
            track_ceiling = RST_TRACK_MAX;
            vol_level     = RST_VOLUME;
            track_no      = RST_TRACK;
            prompt_no     = RST_PROMPT;
            frame_bytes_due.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_VOLUME_STEP: vol_step      = cfg_data[3:0];
                    REG_VOLUME_MAX:  vol_ceiling   = cfg_data;
                    REG_TRACK_MAX:   track_ceiling = cfg_data;
                    default:         ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("unexpected output transaction: tx_byte %h, last_byte %b",
                           tx_byte, last_byte);
                    mismatches++;
                end
                else
                begin
                    oldest = frame_bytes_due.pop_front();
                    if (tx_byte !== oldest.tx)
                    begin
                        $error("tx_byte: expected %h, actual %h", oldest.tx, tx_byte);
                        mismatches++;
                    end
                    if (last_byte !== oldest.last)
                    begin
                        $error("last_byte: expected %b, actual %b", oldest.last, last_byte);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_request(volume_request, prompt_request, music_request);
            fail_count <= mismatches;
            pending    <= frame_bytes_due.size();
        end
    end

endmodule

FILE: dv/mp3_player_command_framer_top_test.sv
// ----------------------------------------------------------------------------
// mp3_player_command_framer_top_test
// Drives volume, prompt and music requests and register settings into the
// command framer with random idling on both sides; the checker beside the
// block predicts and compares every byte sent.
// ----------------------------------------------------------------------------
module mp3_player_command_framer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mpf_pkg::*;

    localparam int         MAX_GAP         = 17;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         SETTLE_CYCLES   = 32;
    localparam int         RANDOM_PHASES   = 7;
    localparam int         ITEMS_PER_PHASE = 50;
    localparam logic [1:0] REG_SPARE       = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] volume_request;
    logic [7:0] prompt_request;
    logic [7:0] music_request;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] tx_byte;
    logic       last_byte;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit steady_sender;
    bit hold_off_req;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    mp3_player_command_framer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .volume_request (volume_request),
        .prompt_request (prompt_request),
        .music_request  (music_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_byte        (tx_byte),
        .last_byte      (last_byte)
    );

    mp3_player_command_framer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .volume_request (volume_request),
        .prompt_request (prompt_request),
        .music_request  (music_request),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_byte        (tx_byte),
        .last_byte      (last_byte),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Ends the run if no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Frame receiver: stalls a random number of cycles before every byte outside
    // steady stretches, and once holds off for a long stretch so that the block backs up.
    initial
    begin : frame_receiver
        int hold;
        int taken;
        bit steady;
        out_stall <= 1'b0;
        taken = 0;
        steady = 1'b0;
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold = HOLD_OFF_CYCLES;
            end
            else
                hold = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    task automatic send_request(input logic [7:0] vreq, input logic [7:0] preq,
                                input logic [7:0] mreq);
        int gap;
        gap = steady_sender ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        volume_request <= vreq;
        prompt_request <= preq;
        music_request  <= mreq;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Waits until every predicted byte has gone out and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] step, input logic [7:0] vmax,
                              input logic [7:0] tmax);
        cfg_write <= 1'b1;
        cfg_index <= REG_VOLUME_STEP;
        cfg_data  <= {4'd0, step};
        @(posedge clk);
        cfg_index <= REG_VOLUME_MAX;
        cfg_data  <= vmax;
        @(posedge clk);
        cfg_index <= REG_TRACK_MAX;
        cfg_data  <= tmax;
        @(posedge clk);
        // The spare index must leave every setting alone.
        cfg_index <= REG_SPARE;
        cfg_data  <= 8'($urandom_range(0, 255));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] pick_code(input int specials);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return REQ_NONE;
        if (r < 7)
            return 8'($urandom_range(1, specials));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_limit(input int hi);
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'(hi);
            2:       return 8'($urandom_range(0, 10));
            default: return 8'($urandom_range(0, hi));
        endcase
    endfunction

    initial
    begin : request_source
        int         phase;
        int         n;
        logic [7:0] step_pick;
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= REG_VOLUME_STEP;
        cfg_data       <= 8'd0;
        in_valid       <= 1'b0;
        volume_request <= REQ_NONE;
        prompt_request <= REQ_NONE;
        music_request  <= REQ_NONE;
        steady_sender = 1'b0;
        hold_off_req  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings from reset: every code at least once, wraps at both ends of the tracks.
        send_request(REQ_NONE, REQ_NONE, REQ_NONE);
        send_request(VOL_DOWN, REQ_NONE, REQ_NONE);
        send_request(VOL_UP, REQ_NONE, REQ_NONE);
        send_request(8'h03, REQ_NONE, REQ_NONE);
        send_request(8'hFF, REQ_NONE, REQ_NONE);
        send_request(REQ_NONE, 8'h01, REQ_NONE);
        send_request(REQ_NONE, 8'hFF, REQ_NONE);
        send_request(REQ_NONE, REQ_NONE, MUS_PREV);
        send_request(REQ_NONE, REQ_NONE, MUS_NEXT);
        send_request(REQ_NONE, REQ_NONE, MUS_NEXT);
        send_request(REQ_NONE, REQ_NONE, MUS_STOP);
        send_request(REQ_NONE, REQ_NONE, 8'h05);
        send_request(REQ_NONE, REQ_NONE, MUS_FIRST);
        send_request(8'hFF, 8'hFF, 8'hFF);
        send_request(VOL_UP, 8'h5A, MUS_STOP);

        // Largest step against a low ceiling, and the widest track range.
        drain();
        set_config(4'd15, 8'd20, 8'd255);
        send_request(VOL_UP, REQ_NONE, REQ_NONE);
        send_request(VOL_UP, REQ_NONE, REQ_NONE);
        send_request(REQ_NONE, REQ_NONE, MUS_PREV);
        send_request(REQ_NONE, REQ_NONE, MUS_NEXT);
        send_request(REQ_NONE, REQ_NONE, MUS_PREV);

        // Ceilings lowered under the stored volume and track.
        drain();
        set_config(4'd15, 8'd5, 8'd7);
        send_request(VOL_DOWN, REQ_NONE, REQ_NONE);
        send_request(REQ_NONE, REQ_NONE, MUS_PREV);

        // Zero step, zero volume ceiling and a track ceiling of zero.
        drain();
        set_config(4'd0, 8'd0, 8'd0);
        send_request(VOL_UP, REQ_NONE, REQ_NONE);
        send_request(REQ_NONE, REQ_NONE, MUS_NEXT);
        send_request(REQ_NONE, REQ_NONE, MUS_PREV);

        drain();
        set_config(4'd15, 8'd255, 8'd1);
        send_request(VOL_DOWN, REQ_NONE, REQ_NONE);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            step_pick = pick_limit(15);
            set_config(step_pick[3:0], pick_limit(255), pick_limit(255));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % 25 == 0)
                    steady_sender = ($urandom_range(0, 3) == 0);
                if (phase == 1 && n == 5)
                begin
                    hold_off_req  = 1'b1;
                    steady_sender = 1'b1;
                end
                send_request(pick_code(3), pick_code(255), pick_code(5));
            end
        end

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/mpf_pkg.sv
rtl/mpf_front.sv
rtl/mpf_queue.sv
rtl/mpf_back.sv
rtl/mp3_player_command_framer_top.sv
dv/mp3_player_command_framer_checker.sv
dv/mp3_player_command_framer_top_test.sv
